// ===== hdl/ifs_pkg.sv =====
// Shared types, frame layout constants and the CRC-16/MODBUS byte update for the IMU frame serializer.
package ifs_pkg;

  localparam int unsigned FrameBytes = 34;
  localparam int unsigned ChainBytes = 32;
  localparam int unsigned CrcStart   = 2;
  localparam int unsigned CntW       = $clog2(FrameBytes);
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 16;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  typedef enum logic [CfgIdxW-1:0] {
    CfgStartA     = 3'd0,
    CfgStartB     = 3'd1,
    CfgVersion    = 3'd2,
    CfgMsgType    = 3'd3,
    CfgPayloadLen = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic        [15:0] sequence_number;
    logic        [31:0] uptime_ms;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [31:0] gyro_x;
    logic signed [31:0] gyro_y;
    logic signed [31:0] gyro_z;
    logic signed [15:0] temperature_centi;
  } sample_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
  } result_t;

  // Control for the byte chain: parallel load or a shift towards the head.
  typedef struct packed {
    logic load;
    logic shift;
  } chain_ctrl_t;

  // Control for the CRC register: reseed or absorb one byte.
  typedef struct packed {
    logic clear;
    logic update;
  } crc_ctrl_t;

  // Reflected CRC-16 over one byte, eight bit steps.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== hdl/ifs_cell.sv =====
// One byte cell of the frame chain: loads its frame byte or takes its neighbour's byte.
module ifs_cell (
  input  logic                clk_i,
  input  ifs_pkg::chain_ctrl_t ctrl_i,
  input  logic [7:0]          load_byte_i,
  input  logic [7:0]          next_byte_i,
  output logic [7:0]          byte_o
);
  import ifs_pkg::*;

  logic [7:0] byte_q, byte_d;

  always_comb begin
    byte_d = byte_q;
    if (ctrl_i.load) begin
      byte_d = load_byte_i;
    end else if (ctrl_i.shift) begin
      byte_d = next_byte_i;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign byte_o = byte_q;

endmodule

// ===== hdl/ifs_crc.sv =====
// CRC-16/MODBUS accumulator that absorbs one frame byte per cycle while its update control is high.
module ifs_crc (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ifs_pkg::crc_ctrl_t ctrl_i,
  input  logic [7:0]        data_i,
  output logic [15:0]       crc_o
);
  import ifs_pkg::*;

  logic [15:0] crc_q, crc_d;

  always_comb begin
    crc_d = crc_q;
    if (ctrl_i.clear) begin
      crc_d = CrcInit;
    end else if (ctrl_i.update) begin
      crc_d = crc16_byte(crc_q, data_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= CrcInit;
    end else begin
      crc_q <= crc_d;
    end
  end

  assign crc_o = crc_q;

endmodule

// ===== hdl/imu_frame_serializer_crc16_core.sv =====
// Top level of the IMU frame serializer: config registers, byte chain, CRC and sequencing.
//
// Usage. A sample is taken on a rising edge at which start_i is high and busy_o is low; the
// sample_i struct carries the sequence number and the sensor readings. The block then puts
// out a 34-byte frame, one byte per cycle, starting in the cycle after the transfer: each
// byte sits on result_o for exactly one cycle with result_valid_o high, and the final CRC
// high byte carries frame_end. The output is byte-wide: busy_o drops in the cycle of the
// last byte, so a new sample can be taken then and its frame follows with no gap.
// Internally the 32 header and payload bytes are loaded in parallel into a chain of byte
// cells which shifts one place towards the head each cycle; the CRC unit absorbs each byte
// after the two start bytes at the head as it leaves, and the CRC's two bytes are appended
// after the chain has drained. The receiver cannot stall the block; a result transfer
// completes in every valid cycle. Configuration is to be written through cfg_we_i, cfg_idx_i
// and cfg_wdata_i while idle, which the block itself does not enforce; indexes beyond the
// register list are ignored. Reset returns the header registers to their defaults,
// clears the sequencer and needs no clearing pass.
module imu_frame_serializer_crc16_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  ifs_pkg::sample_t                   sample_i,
  output logic                               result_valid_o,
  output ifs_pkg::result_t                   result_o,
  input  logic                               cfg_we_i,
  input  logic [ifs_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [ifs_pkg::CfgDataW-1:0]       cfg_wdata_i
);
  import ifs_pkg::*;

  localparam logic [CntW-1:0] LastIdx     = CntW'(FrameBytes - 1);
  localparam logic [CntW-1:0] CrcLoIdx    = CntW'(ChainBytes);
  localparam logic [CntW-1:0] CrcFirstIdx = CntW'(CrcStart);

  // Header registers.
  logic [7:0]  start_a_q, start_b_q, version_q, msg_type_q;
  logic [15:0] payload_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_a_q     <= 8'd0;
      start_b_q     <= 8'd0;
      version_q     <= 8'd1;
      msg_type_q    <= 8'd0;
      payload_len_q <= 16'd24;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgStartA:     start_a_q     <= cfg_wdata_i[7:0];
        CfgStartB:     start_b_q     <= cfg_wdata_i[7:0];
        CfgVersion:    version_q     <= cfg_wdata_i[7:0];
        CfgMsgType:    msg_type_q    <= cfg_wdata_i[7:0];
        CfgPayloadLen: payload_len_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Sequencer: byte position within the frame in flight.
  logic            active_q, active_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            accept;
  logic            last_byte;

  assign last_byte = active_q && (cnt_q == LastIdx);
  assign busy_o    = active_q && !last_byte;
  assign accept    = start_i && !busy_o;

  always_comb begin
    active_d = active_q;
    cnt_d    = cnt_q;
    if (accept) begin
      active_d = 1'b1;
      cnt_d    = '0;
    end else if (active_q) begin
      if (last_byte) begin
        active_d = 1'b0;
      end
      cnt_d = cnt_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      active_q <= active_d;
      cnt_q    <= cnt_d;
    end
  end

  // Frame bytes in transmit order, all multi-byte values little-endian.
  logic [7:0] load_bytes [ChainBytes];

  always_comb begin
    load_bytes[0]  = start_a_q;
    load_bytes[1]  = start_b_q;
    load_bytes[2]  = version_q;
    load_bytes[3]  = msg_type_q;
    load_bytes[4]  = sample_i.sequence_number[7:0];
    load_bytes[5]  = sample_i.sequence_number[15:8];
    load_bytes[6]  = payload_len_q[7:0];
    load_bytes[7]  = payload_len_q[15:8];
    for (int i = 0; i < 4; i++) begin
      load_bytes[8 + i]  = sample_i.uptime_ms[8*i +: 8];
      load_bytes[18 + i] = sample_i.gyro_x[8*i +: 8];
      load_bytes[22 + i] = sample_i.gyro_y[8*i +: 8];
      load_bytes[26 + i] = sample_i.gyro_z[8*i +: 8];
    end
    for (int i = 0; i < 2; i++) begin
      load_bytes[12 + i] = sample_i.accel_x[8*i +: 8];
      load_bytes[14 + i] = sample_i.accel_y[8*i +: 8];
      load_bytes[16 + i] = sample_i.accel_z[8*i +: 8];
      load_bytes[30 + i] = sample_i.temperature_centi[8*i +: 8];
    end
  end

  // The byte chain: cell 0 is the head, each cell but the last takes its upper neighbour's byte.
  chain_ctrl_t chain_ctrl;
  logic [7:0]  cell_bytes [ChainBytes];

  assign chain_ctrl.load  = accept;
  assign chain_ctrl.shift = active_q;

  for (genvar g = 0; g < ChainBytes; g++) begin : g_cell
    logic [7:0] next_byte;
    if (g == ChainBytes - 1) begin : g_tail
      assign next_byte = 8'h00;
    end else begin : g_body
      assign next_byte = cell_bytes[g + 1];
    end
    ifs_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (chain_ctrl),
      .load_byte_i (load_bytes[g]),
      .next_byte_i (next_byte),
      .byte_o      (cell_bytes[g])
    );
  end

  // CRC over every byte after the two start bytes, taken from the head as it leaves.
  crc_ctrl_t   crc_ctrl;
  logic [15:0] crc;

  assign crc_ctrl.clear  = accept;
  assign crc_ctrl.update = active_q && (cnt_q >= CrcFirstIdx) && (cnt_q < CrcLoIdx);

  ifs_crc u_crc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (crc_ctrl),
    .data_i (cell_bytes[0]),
    .crc_o  (crc)
  );

  // Output selection: chain head, then CRC low byte, then CRC high byte.
  always_comb begin
    if (cnt_q < CrcLoIdx) begin
      result_o.frame_byte = cell_bytes[0];
    end else if (cnt_q == CrcLoIdx) begin
      result_o.frame_byte = crc[7:0];
    end else begin
      result_o.frame_byte = crc[15:8];
    end
    result_o.frame_end = last_byte;
  end

  assign result_valid_o = active_q;

  // Checks on the sequencing.
  a_accept_starts_frame : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (result_valid_o && (cnt_q == '0)))
    else $error("accepted sample did not start a frame");

  a_end_only_when_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.frame_end |-> result_valid_o)
    else $error("frame end flagged outside a valid byte");

  a_mid_frame_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !result_o.frame_end) |-> busy_o)
    else $error("not busy in the middle of a frame");

  a_idle_after_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.frame_end && !start_i) |=> !result_valid_o)
    else $error("bytes continued after frame end without a new sample");

  a_frame_continues : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !result_o.frame_end) |=>
      (result_valid_o && (cnt_q == $past(cnt_q) + CntW'(1))))
    else $error("frame broken off before its last byte");

endmodule

// ===== test/imu_frame_checker.sv =====
// Scoreboard for the IMU frame serializer: predicts every frame byte and compares it on arrival.
module imu_frame_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic                         busy_i,
  input  ifs_pkg::sample_t             sample_i,
  input  logic                         result_valid_i,
  input  ifs_pkg::result_t             result_i,
  input  logic                         cfg_we_i,
  input  logic [ifs_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ifs_pkg::CfgDataW-1:0] cfg_wdata_i,
  output int                           fail_count_o,
  output int                           pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import ifs_pkg::*;

  localparam logic [15:0] ModbusSeed = 16'hFFFF;
  localparam logic [15:0] ModbusPoly = 16'hA001;
  // Bytes covered by the CRC: everything between the start bytes and the CRC itself.
  localparam int unsigned CoveredBytes = FrameBytes - CrcStart - 2;

  logic [7:0]  sof_a;
  logic [7:0]  sof_b;
  logic [7:0]  version;
  logic [7:0]  msg_type;
  logic [15:0] length_field;

  result_t frame_q[$];
  result_t oldest;
  int      failures = 0;

  function automatic logic [15:0] modbus_crc(input logic [CoveredBytes*8-1:0] body);
    logic [15:0] crc;
    crc = ModbusSeed;
    for (int k = 0; k < CoveredBytes; k++) begin
      crc = crc ^ {8'h00, body[8*k +: 8]};
      for (int b = 0; b < 8; b++) begin
        crc = crc[0] ? ((crc >> 1) ^ ModbusPoly) : (crc >> 1);
      end
    end
    return crc;
  endfunction

  // Appends one expected byte at the tail of the queue.
  function automatic void add_expected(input logic [7:0] data, input logic last);
    result_t item;
    item.frame_byte = data;
    item.frame_end  = last;
    frame_q.insert(frame_q.size(), item);
  endfunction

  // Packing the fields low byte first gives the little-endian byte order directly.
  function automatic void queue_frame(input sample_t s);
    logic [CoveredBytes*8-1:0] body;
    logic [15:0]               crc;
    body = {s.temperature_centi, s.gyro_z, s.gyro_y, s.gyro_x,
            s.accel_z, s.accel_y, s.accel_x, s.uptime_ms,
            length_field, s.sequence_number, msg_type, version};
    crc = modbus_crc(body);
    add_expected(sof_a, 1'b0);
    add_expected(sof_b, 1'b0);
    for (int k = 0; k < CoveredBytes; k++) begin
      add_expected(body[8*k +: 8], 1'b0);
    end
    add_expected(crc[7:0], 1'b0);
    add_expected(crc[15:8], 1'b1);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sof_a        = 8'h00;
      sof_b        = 8'h00;
      version      = 8'h01;
      msg_type     = 8'h00;
      length_field = 16'd24;
      frame_q.delete();
      pending_o    <= 0;
      fail_count_o <= failures;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgStartA:     sof_a        = cfg_wdata_i[7:0];
          CfgStartB:     sof_b        = cfg_wdata_i[7:0];
          CfgVersion:    version      = cfg_wdata_i[7:0];
          CfgMsgType:    msg_type     = cfg_wdata_i[7:0];
          CfgPayloadLen: length_field = cfg_wdata_i;
          default: ;
        endcase
      end
      if (start_i && !busy_i) begin
        queue_frame(sample_i);
      end
      if (result_valid_i) begin
        if (frame_q.size() == 0) begin
          failures++;
          $display("%0t: unexpected byte: expected none, actual %02h end %0b",
                   $time, result_i.frame_byte, result_i.frame_end);
        end else begin
          oldest = frame_q.pop_front();
          if (result_i.frame_byte !== oldest.frame_byte) begin
            failures++;
            $display("%0t: frame_byte mismatch: expected %02h, actual %02h",
                     $time, oldest.frame_byte, result_i.frame_byte);
          end
          if (result_i.frame_end !== oldest.frame_end) begin
            failures++;
            $display("%0t: frame_end mismatch: expected %0b, actual %0b",
                     $time, oldest.frame_end, result_i.frame_end);
          end
        end
      end
      pending_o    <= frame_q.size();
      fail_count_o <= failures;
    end
  end

endmodule

// ===== test/tb_imu_frame_serializer_crc16_core.sv =====
// Testbench top for the IMU frame serializer: clock, reset, sample stimulus and the verdict.
module tb_imu_frame_serializer_crc16_core;
  timeunit 1ns;
  timeprecision 1ps;
  import ifs_pkg::*;

  localparam int unsigned ClkPeriod    = 8;
  localparam int unsigned ResetCycles  = 8;
  // A correct run needs roughly 150 samples times 34 bytes plus gaps, so this limit leaves
  // a wide margin.
  localparam int unsigned CycleLimit   = 400_000;
  // Long enough for a frame's last byte to leave after its sample transfer, with a little margin.
  localparam int unsigned DrainCycles  = FrameBytes + 8;
  localparam int unsigned RandomPhases = 5;
  localparam int unsigned PhaseItems   = 26;
  // The phase in which the sender never pauses between samples.
  localparam int unsigned SteadyPhase  = 2;
  localparam int unsigned GapPercent   = 20;
  localparam int unsigned MaxGap       = 40;
  // Register indexes from here up to the top of the index range address nothing.
  localparam int unsigned RegCount     = 5;
  localparam logic [CfgIdxW-1:0] CfgIdxTop = '1;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                start_i;
  logic                busy_o;
  sample_t             sample_i;
  logic                result_valid_o;
  result_t             result_o;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  int fail_count;
  int bytes_pending;
  int cycle_count = 0;
  bit gaps_on;

  imu_frame_serializer_crc16_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .sample_i       (sample_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  // The checker sits beside the block and sees exactly what crosses its ports.
  imu_frame_checker frame_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_i         (busy_o),
    .sample_i       (sample_i),
    .result_valid_i (result_valid_o),
    .result_i       (result_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .fail_count_o   (fail_count),
    .pending_o      (bytes_pending)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Watchdog: a hung handshake or a missing frame ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("FAIL imu_frame_serializer_crc16_core");
      $finish;
    end
  end

  // Uniform values for half the picks, the four corner patterns of a word for the other half.
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'h7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick_half();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h8000;
      3:       return 16'h7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic sample_t random_sample();
    sample_t s;
    s.sequence_number   = pick_half();
    s.uptime_ms         = pick_word();
    s.accel_x           = pick_half();
    s.accel_y           = pick_half();
    s.accel_z           = pick_half();
    s.gyro_x            = pick_word();
    s.gyro_y            = pick_word();
    s.gyro_z            = pick_word();
    s.temperature_centi = pick_half();
    return s;
  endfunction

  // Directed samples: every 16-bit field carries one pattern, every 32-bit field another.
  function automatic sample_t pattern_sample(input logic [15:0] half, input logic [31:0] word);
    sample_t s;
    s.sequence_number   = half;
    s.uptime_ms         = word;
    s.accel_x           = half;
    s.accel_y           = half;
    s.accel_z           = half;
    s.gyro_x            = word;
    s.gyro_y            = word;
    s.gyro_z            = word;
    s.temperature_centi = half;
    return s;
  endfunction

  // One register write per clock; the caller lowers the write enable after the last one,
  // so that back-to-back writes never see the enable dropped and raised in the same step.
  task automatic put_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
  endtask

  // Writes the whole header, then one write to an unused index, which must change nothing.
  // Values wider than an 8-bit register are passed on purpose: only the low byte may count.
  task automatic load_header(input logic [CfgDataW-1:0] sof_a, input logic [CfgDataW-1:0] sof_b,
                             input logic [CfgDataW-1:0] version,
                             input logic [CfgDataW-1:0] msg_type,
                             input logic [CfgDataW-1:0] length_field);
    put_reg(CfgStartA, sof_a);
    put_reg(CfgStartB, sof_b);
    put_reg(CfgVersion, version);
    put_reg(CfgMsgType, msg_type);
    put_reg(CfgPayloadLen, length_field);
    put_reg(CfgIdxW'($urandom_range(RegCount, CfgIdxTop)), 16'($urandom));
    cfg_we_i <= 1'b0;
  endtask

  // Holds the sender back until every expected byte has arrived and the block is idle.
  // Configuration writes are only made after this.
  task automatic drain();
    start_i <= 1'b0;
    wait (bytes_pending == 0);
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  // Offers one sample and returns at the edge of its transfer. With gaps enabled the sender
  // sometimes withdraws first, for a spell long enough to land anywhere within a frame.
  task automatic send(input sample_t s);
    if (gaps_on && $urandom_range(0, 99) < GapPercent) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, MaxGap)) @(posedge clk_i);
    end
    start_i  <= 1'b1;
    sample_i <= s;
    do @(posedge clk_i); while (busy_o);
  endtask

  initial begin
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    sample_i    = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = '0;
    cfg_wdata_i = '0;
    gaps_on     = 1'b0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Header registers at their reset values, extremes of every field, sent back to back so
    // that each new transfer lands in the cycle of the previous frame's last byte.
    send(pattern_sample(16'h0000, 32'h0000_0000));
    send(pattern_sample(16'hFFFF, 32'hFFFF_FFFF));
    send(pattern_sample(16'h7FFF, 32'h7FFF_FFFF));
    send(pattern_sample(16'h8000, 32'h8000_0000));
    send(pattern_sample(16'h5555, 32'hAAAA_AAAA));
    send(pattern_sample(16'hAAAA, 32'h5555_5555));
    send(pattern_sample(16'h0001, 32'hFFFF_FFFE));

    // Smallest header values.
    drain();
    load_header(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send(pattern_sample(16'h0000, 32'h0000_0000));
    send(pattern_sample(16'hFFFF, 32'hFFFF_FFFF));
    send(pattern_sample(16'h8000, 32'h7FFF_FFFF));

    // Largest header values; the 8-bit registers are given all sixteen bits set.
    drain();
    load_header(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send(pattern_sample(16'h0000, 32'h0000_0000));
    send(pattern_sample(16'hFFFF, 32'hFFFF_FFFF));
    send(pattern_sample(16'h7FFF, 32'h8000_0000));

    // A typical header with junk in the upper byte of each 8-bit register.
    drain();
    load_header(16'h12AA, 16'h3455, 16'h5601, 16'h7810, 16'h0018);
    send(pattern_sample(16'h1234, 32'hDEAD_BEEF));
    send(random_sample());

    // Random part: each phase has its own random header; one phase runs without any pauses.
    for (int p = 0; p < RandomPhases; p++) begin
      drain();
      load_header(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      gaps_on = (p != SteadyPhase);
      for (int i = 0; i < PhaseItems; i++) begin
        send(random_sample());
      end
    end

    // Let the last frame run out, then allow a few more cycles for any stray byte.
    start_i <= 1'b0;
    wait (bytes_pending == 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0 && bytes_pending == 0) begin
      $display("PASS imu_frame_serializer_crc16_core");
    end else begin
      $display("FAIL imu_frame_serializer_crc16_core");
    end
    $finish;
  end

endmodule
